@@ design/qty_pkg.sv @@
// shared constants, types and the arctangent table for the quaternion-to-yaw block
// no dependencies; used by the interfaces and every design module
package qty_pkg;

    localparam int COMPONENT_WIDTH = 16;
    localparam int CORDIC_STEPS    = 16;
    localparam int ATAN_TAB_LEN    = 24;
    localparam int STEPS           = (CORDIC_STEPS > ATAN_TAB_LEN) ? ATAN_TAB_LEN : CORDIC_STEPS;
    localparam int STEP_IDX_W      = $clog2(ATAN_TAB_LEN);

    localparam int FRAC2   = 2 * (COMPONENT_WIDTH - 2);
    localparam int PROD_W  = 2 * COMPONENT_WIDTH;
    localparam int SHIFT_G = (PROD_W > 42) ? (PROD_W - 42) : 0;
    localparam int SUM_W   = PROD_W - SHIFT_G + 1;
    // room for cordic gain and the quarter-turn pre-rotation
    localparam int DATA_W  = SUM_W + 3;
    // angle accumulator, 2^31 = pi
    localparam int ACC_W   = 34;
    localparam int YAW_W   = 16;

    localparam logic signed [SUM_W-1:0] B_BIAS     = SUM_W'(1) << (FRAC2 - 1 - SHIFT_G);
    localparam logic signed [ACC_W-1:0] QUARTER    = ACC_W'(1) << 30;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << 15;

    typedef struct packed {
        logic                     zero;
        logic signed [DATA_W-1:0] xr;
        logic signed [DATA_W-1:0] yr;
        logic signed [ACC_W-1:0]  acc;
    } cordic_t;

    // atan(2^-i) / pi * 2^31, rounded
    function automatic logic signed [ACC_W-1:0] atan_entry(input logic [STEP_IDX_W-1:0] idx);
        logic signed [ACC_W-1:0] val;
        case (idx)
            5'd0:    val = ACC_W'(34'h020000000);
            5'd1:    val = ACC_W'(34'h012E4051E);
            5'd2:    val = ACC_W'(34'h009FB385B);
            5'd3:    val = ACC_W'(34'h0051111D4);
            5'd4:    val = ACC_W'(34'h0028B0D43);
            5'd5:    val = ACC_W'(34'h00145D7E1);
            5'd6:    val = ACC_W'(34'h000A2F61E);
            5'd7:    val = ACC_W'(34'h000517C55);
            5'd8:    val = ACC_W'(34'h00028BE53);
            5'd9:    val = ACC_W'(34'h000145F2F);
            5'd10:   val = ACC_W'(34'h0000A2F98);
            5'd11:   val = ACC_W'(34'h0000517CC);
            5'd12:   val = ACC_W'(34'h000028BE6);
            5'd13:   val = ACC_W'(34'h0000145F3);
            5'd14:   val = ACC_W'(34'h00000A2FA);
            5'd15:   val = ACC_W'(34'h00000517D);
            5'd16:   val = ACC_W'(34'h0000028BE);
            5'd17:   val = ACC_W'(34'h00000145F);
            5'd18:   val = ACC_W'(34'h000000A30);
            5'd19:   val = ACC_W'(34'h000000518);
            5'd20:   val = ACC_W'(34'h00000028C);
            5'd21:   val = ACC_W'(34'h000000146);
            5'd22:   val = ACC_W'(34'h0000000A3);
            5'd23:   val = ACC_W'(34'h000000051);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

@@ design/qty_quat_if.sv @@
// input channel: one quaternion per transaction
// depends on qty_pkg for the component width
interface qty_quat_if;
    logic                                          valid;
    logic                                          ready;
    logic signed [qty_pkg::COMPONENT_WIDTH-1:0]    quat_x;
    logic signed [qty_pkg::COMPONENT_WIDTH-1:0]    quat_y;
    logic signed [qty_pkg::COMPONENT_WIDTH-1:0]    quat_z;
    logic signed [qty_pkg::COMPONENT_WIDTH-1:0]    quat_w;

    modport source (output valid, output quat_x, output quat_y, output quat_z,
                    output quat_w, input ready);
    modport sink   (input valid, input quat_x, input quat_y, input quat_z,
                    input quat_w, output ready);
endinterface

@@ design/qty_yaw_if.sv @@
// output channel: one yaw angle per transaction
// depends on qty_pkg for the angle width
interface qty_yaw_if;
    logic                              valid;
    logic                              ready;
    logic signed [qty_pkg::YAW_W-1:0]  yaw_angle;

    modport source (output valid, output yaw_angle, input ready);
    modport sink   (input valid, input yaw_angle, output ready);
endinterface

@@ design/qty_front.sv @@
// front end: products, the a/b sums and the half-plane pre-rotation, three stages
// depends on qty_pkg and qty_quat_if
module qty_front (
    input  logic             clk,
    input  logic             rst_n,
    qty_quat_if.sink         quat,
    output logic             out_valid,
    input  logic             out_ready,
    output qty_pkg::cordic_t out_data
);

    logic                                 p_valid_reg;
    logic signed [qty_pkg::PROD_W-1:0]    wz_reg, xy_reg, yy_reg, zz_reg;
    logic                                 s_valid_reg;
    logic signed [qty_pkg::SUM_W-1:0]     a_reg, b_reg;
    logic                                 r_valid_reg;
    qty_pkg::cordic_t                     r_data_reg;

    logic                                 p_ready, s_ready, r_ready;
    logic signed [qty_pkg::SUM_W-1:0]     a_next, b_next;
    logic signed [qty_pkg::DATA_W-1:0]    a_ext, b_ext;
    qty_pkg::cordic_t                     r_data_next;

    assign r_ready    = !r_valid_reg || out_ready;
    assign s_ready    = !s_valid_reg || r_ready;
    assign p_ready    = !p_valid_reg || s_ready;
    assign quat.ready = p_ready;

    assign a_next = qty_pkg::SUM_W'(wz_reg >>> qty_pkg::SHIFT_G)
                  + qty_pkg::SUM_W'(xy_reg >>> qty_pkg::SHIFT_G);
    assign b_next = qty_pkg::B_BIAS
                  - qty_pkg::SUM_W'(yy_reg >>> qty_pkg::SHIFT_G)
                  - qty_pkg::SUM_W'(zz_reg >>> qty_pkg::SHIFT_G);

    assign a_ext = qty_pkg::DATA_W'(a_reg);
    assign b_ext = qty_pkg::DATA_W'(b_reg);

    always_comb
    begin
        r_data_next.zero = (a_reg == '0) && (b_reg == '0);
        if (b_reg < 0)
        begin
            // left half plane: quarter turn into the right half first
            if (a_reg >= 0)
            begin
                r_data_next.xr  = a_ext;
                r_data_next.yr  = -b_ext;
                r_data_next.acc = qty_pkg::QUARTER;
            end
            else
            begin
                r_data_next.xr  = -a_ext;
                r_data_next.yr  = b_ext;
                r_data_next.acc = -qty_pkg::QUARTER;
            end
        end
        else
        begin
            r_data_next.xr  = b_ext;
            r_data_next.yr  = a_ext;
            r_data_next.acc = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_ready)
                p_valid_reg <= quat.valid;
            if (s_ready)
                s_valid_reg <= p_valid_reg;
            if (r_ready)
                r_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_ready && quat.valid)
        begin
            wz_reg <= qty_pkg::PROD_W'(quat.quat_w) * qty_pkg::PROD_W'(quat.quat_z);
            xy_reg <= qty_pkg::PROD_W'(quat.quat_x) * qty_pkg::PROD_W'(quat.quat_y);
            yy_reg <= qty_pkg::PROD_W'(quat.quat_y) * qty_pkg::PROD_W'(quat.quat_y);
            zz_reg <= qty_pkg::PROD_W'(quat.quat_z) * qty_pkg::PROD_W'(quat.quat_z);
        end
        if (s_ready && p_valid_reg)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
        if (r_ready && s_valid_reg)
            r_data_reg <= r_data_next;
    end

    assign out_valid = r_valid_reg;
    assign out_data  = r_data_reg;

endmodule

@@ design/qty_cell.sv @@
// one cordic vectoring iteration with its own pipeline register
// depends on qty_pkg for the data type and the arctangent table
module qty_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [qty_pkg::STEP_IDX_W-1:0]     step,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  qty_pkg::cordic_t                   in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output qty_pkg::cordic_t                   out_data
);

    logic                               valid_reg;
    qty_pkg::cordic_t                   data_reg;
    qty_pkg::cordic_t                   data_next;
    logic signed [qty_pkg::DATA_W-1:0]  dx, dy;
    logic signed [qty_pkg::ACC_W-1:0]   angle;

    assign in_ready = !valid_reg || out_ready;

    assign dx    = in_data.yr >>> step;
    assign dy    = in_data.xr >>> step;
    assign angle = qty_pkg::atan_entry(step);

    always_comb
    begin
        data_next.zero = in_data.zero;
        if (in_data.yr >= 0)
        begin
            // clockwise
            data_next.xr  = in_data.xr + dx;
            data_next.yr  = in_data.yr - dy;
            data_next.acc = in_data.acc + angle;
        end
        else
        begin
            data_next.xr  = in_data.xr - dx;
            data_next.yr  = in_data.yr + dy;
            data_next.acc = in_data.acc - angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ design/quaternion_to_yaw_core.sv @@
// top level: yaw angle of an orientation quaternion via an unrolled cordic
// depends on qty_pkg, qty_quat_if, qty_yaw_if, qty_front and qty_cell
//
// usage
//   quat carries one quaternion (quat_x, quat_y, quat_z, quat_w, signed q2.14)
//   per transaction; yaw carries one yaw_angle per transaction, a 16-bit
//   binary angle where 32768 is pi, so +pi comes out as -32768
//   a zero vector (both atan2 arguments zero) gives 0
//   from input transaction to yaw valid a quaternion passes the product,
//   sum and pre-rotation registers, one register per cordic cell and the
//   rounding register; throughput is one quaternion per cycle while
//   yaw.ready is high; every cell is its own pipeline stage and the ready
//   chain runs back through all of them
//   reset clears every stage valid bit; no clearing pass, quat.ready is high
//   in the first cycle after reset
//   when the receiver holds yaw.ready low the result stays in the output
//   register, stages behind it keep filling, and quat.ready drops only once
//   every stage holds an item
module quaternion_to_yaw_core (
    input  logic       clk,
    input  logic       rst_n,
    qty_quat_if.sink   quat,
    qty_yaw_if.source  yaw
);

    localparam int LAST = qty_pkg::STEPS;

    logic [LAST:0]     chain_valid;
    logic [LAST:0]     chain_ready;
    qty_pkg::cordic_t  chain_data [0:LAST];

    logic                                out_valid_reg;
    logic signed [qty_pkg::YAW_W-1:0]    yaw_reg;
    logic signed [qty_pkg::YAW_W-1:0]    yaw_next;
    logic signed [qty_pkg::ACC_W-1:0]    rounded;
    logic                                out_ready;

    qty_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .quat      (quat),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    for (genvar k = 0; k < LAST; k++)
    begin : g_cell
        qty_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (qty_pkg::STEP_IDX_W'(k)),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_data   (chain_data[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_data  (chain_data[k+1])
        );
    end

    // round to nearest, then keep the low 16 bits of acc / 2^16
    assign rounded   = chain_data[LAST].acc + qty_pkg::ROUND_BIAS;
    assign yaw_next  = chain_data[LAST].zero ? '0 : rounded[31:16];
    assign out_ready = !out_valid_reg || yaw.ready;
    assign chain_ready[LAST] = out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= chain_valid[LAST];
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && chain_valid[LAST])
            yaw_reg <= yaw_next;
    end

    assign yaw.valid     = out_valid_reg;
    assign yaw.yaw_angle = yaw_reg;

    // a ready receiver must open the whole chain back to the input
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        yaw.ready |-> quat.ready)
        else $error("ready chain blocked while receiver is ready");

    // pre-rotation must leave the vector in the right half plane
    a_front_half: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[0] |-> (chain_data[0].xr >= 0))
        else $error("pre-rotated x is negative");

    // vectoring never lets x go negative through the cells
    a_last_half: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[LAST] |-> (chain_data[LAST].xr >= 0))
        else $error("cordic x is negative at the last cell");

endmodule
